### src/two_class_quota_boarding_scheduler_unit_macros.svh
// Assertion macros shared by the scheduler checker.
`ifndef TWO_CLASS_QUOTA_BOARDING_SCHEDULER_UNIT_MACROS_SVH
`define TWO_CLASS_QUOTA_BOARDING_SCHEDULER_UNIT_MACROS_SVH

// Same-cycle implication on the rising edge of clock, off while reset is high.
`define TCQBS_ASSERT_IMPLY(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication on the rising edge of clock, off while reset is high.
`define TCQBS_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

### src/tcqbs_pkg.sv
// Types, codes and constants shared by the scheduler modules.
package tcqbs_pkg;

   localparam int TimeBits        = 16;
   localparam int ActionBits      = 2;
   localparam int CfgBits         = 4;
   localparam int CsrIndexBits    = 1;
   localparam int ServedBits      = 4;
   localparam int SlotWaitBits    = 20;
   localparam int PendingBits     = 7;
   localparam int TotalServedBits = 32;
   localparam int TotalWaitBits   = 40;
   localparam int ReqDataBits     = 16;
   localparam int RspDataBits     = 208;

   localparam logic [CfgBits-1:0] CapacityReset = 4'd10;
   localparam logic [CfgBits-1:0] QuotaReset    = 4'd8;

   // Configuration register indexes.
   localparam logic [CsrIndexBits-1:0] CSR_SLOT_CAPACITY  = 1'b0;
   localparam logic [CsrIndexBits-1:0] CSR_PRIORITY_QUOTA = 1'b1;

   // Request kinds; the fourth code has no effect.
   typedef enum logic [ActionBits-1:0] {
      ACT_PRIORITY_ARRIVE  = 2'd0,
      ACT_SECONDARY_ARRIVE = 2'd1,
      ACT_DEPART           = 2'd2
   } action_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PUSH,
      ST_PASS_QUOTA,
      ST_PASS_SECONDARY,
      ST_PASS_FILL,
      ST_RESULT
   } state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;
      logic push;
      logic pop_priority;
      logic pop_secondary;
      logic emit;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      action_type action;
      logic       priority_ok;
      logic       secondary_ok;
      logic       quota_hit;
      logic       slot_full;
      logic       out_free;
   } status_type;

endpackage

### src/tcqbs_fifo.sv
// Time-stamp queue with a memory, a registered head read and a write bypass.
module tcqbs_fifo #(
   parameter int DEPTH = 64
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              push,
   input  logic                              pop,
   input  logic [tcqbs_pkg::TimeBits-1:0]    push_data,
   output logic [tcqbs_pkg::TimeBits-1:0]    head_data,
   output logic [$clog2(DEPTH+1)-1:0]        count,
   output logic                              full
);
   import tcqbs_pkg::*;

   localparam int AddrW = $clog2(DEPTH);
   localparam int CntW  = $clog2(DEPTH+1);

   logic [TimeBits-1:0] mem [DEPTH];
   logic [AddrW-1:0]    head_ff, head_in;
   logic [CntW-1:0]     count_ff, count_in;
   logic [TimeBits-1:0] rd_ff;
   logic                byp_ff;
   logic [TimeBits-1:0] byp_data_ff;
   logic [AddrW:0]      tail_sum;
   logic [AddrW-1:0]    tail;
   logic                do_push, do_pop;

   // Write address is head plus count, wrapped at the depth.
   always_comb begin
      tail_sum = (AddrW+1)'(head_ff) + (AddrW+1)'(count_ff);
      if (tail_sum >= (AddrW+1)'(DEPTH)) begin
         tail = AddrW'(tail_sum - (AddrW+1)'(DEPTH));
      end else begin
         tail = AddrW'(tail_sum);
      end
   end

   assign full    = (count_ff == CntW'(DEPTH));
   assign do_push = push && !full;
   assign do_pop  = pop && (count_ff != '0);

   // Next head pointer and occupancy.
   always_comb begin
      head_in = head_ff;
      if (do_pop) begin
         head_in = (head_ff == AddrW'(DEPTH-1)) ? '0 : head_ff + 1'b1;
      end
      count_in = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         count_ff <= '0;
         byp_ff   <= 1'b0;
      end else begin
         head_ff  <= head_in;
         count_ff <= count_in;
         byp_ff   <= do_push && (tail == head_in);
      end
   end

   // Memory write and registered read of the next head entry.
   always_ff @(posedge clock) begin
      if (do_push) begin
         mem[tail] <= push_data;
      end
      rd_ff       <= mem[head_in];
      byp_data_ff <= push_data;
   end

   // A head-slot write comes from the bypass until the memory read has it.
   assign head_data = byp_ff ? byp_data_ff : rd_ff;
   assign count     = count_ff;

endmodule

### src/tcqbs_datapath.sv
// Datapath: queues, slot counters, wait sums, running totals and result register.
module tcqbs_datapath #(
   parameter int QUEUE_DEPTH = 64
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  tcqbs_pkg::cmd_type                    cmd,
   output tcqbs_pkg::status_type                 status,
   input  logic [tcqbs_pkg::ReqDataBits-1:0]     req_tdata,
   input  logic [tcqbs_pkg::ActionBits-1:0]      req_tuser,
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   output logic [tcqbs_pkg::RspDataBits-1:0]     rsp_tdata,
   output logic                                  rsp_tuser,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [tcqbs_pkg::CsrIndexBits-1:0]    csr_index,
   input  logic [tcqbs_pkg::CfgBits-1:0]         csr_data
);
   import tcqbs_pkg::*;

   localparam int CntW = $clog2(QUEUE_DEPTH+1);

   logic [CfgBits-1:0]         cap_ff, quota_ff, quota_eff;
   action_type                 act_ff;
   logic [TimeBits-1:0]        time_ff;
   logic                       drop_ff;
   logic [ServedBits-1:0]      p_cnt_ff, s_cnt_ff;
   logic [SlotWaitBits-1:0]    p_wait_ff, s_wait_ff;
   logic [TotalServedBits-1:0] tot_ps_ff, tot_ps_in, tot_ss_ff, tot_ss_in;
   logic [TotalWaitBits-1:0]   tot_pw_ff, tot_pw_in, tot_sw_ff, tot_sw_in;
   logic [TotalServedBits:0]   ps_sum, ss_sum;
   logic [TotalWaitBits:0]     pw_sum, sw_sum;
   logic                       rsp_valid_ff;
   logic [RspDataBits-1:0]     rsp_data_ff;
   logic                       rsp_user_ff;
   logic [TimeBits-1:0]        p_head, s_head;
   logic [CntW-1:0]            p_count, s_count;
   logic                       p_full, s_full;
   logic                       p_push, s_push;
   logic [ServedBits:0]        slot_set;

   // Configuration registers; writes are always taken.
   assign csr_ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff   <= CapacityReset;
         quota_ff <= QuotaReset;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_SLOT_CAPACITY:  cap_ff   <= csr_data;
            CSR_PRIORITY_QUOTA: quota_ff <= csr_data;
            default: ;
         endcase
      end
   end

   assign quota_eff = (quota_ff > cap_ff) ? cap_ff : quota_ff;

   // Queues, one per class.
   assign p_push = cmd.push && (act_ff == ACT_PRIORITY_ARRIVE);
   assign s_push = cmd.push && (act_ff == ACT_SECONDARY_ARRIVE);

   tcqbs_fifo #(.DEPTH(QUEUE_DEPTH)) u_priority_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (p_push),
      .pop       (cmd.pop_priority),
      .push_data (time_ff),
      .head_data (p_head),
      .count     (p_count),
      .full      (p_full)
   );

   tcqbs_fifo #(.DEPTH(QUEUE_DEPTH)) u_secondary_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (s_push),
      .pop       (cmd.pop_secondary),
      .push_data (time_ff),
      .head_data (s_head),
      .count     (s_count),
      .full      (s_full)
   );

   // Request latch, drop flag and per-slot counters and wait sums.
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         act_ff    <= action_type'(req_tuser);
         time_ff   <= req_tdata[TimeBits-1:0];
         drop_ff   <= 1'b0;
         p_cnt_ff  <= '0;
         s_cnt_ff  <= '0;
         p_wait_ff <= '0;
         s_wait_ff <= '0;
      end else begin
         if (cmd.push) begin
            drop_ff <= (act_ff == ACT_PRIORITY_ARRIVE) ? p_full : s_full;
         end
         if (cmd.pop_priority) begin
            p_cnt_ff  <= p_cnt_ff + 1'b1;
            p_wait_ff <= p_wait_ff + SlotWaitBits'(time_ff - p_head);
         end
         if (cmd.pop_secondary) begin
            s_cnt_ff  <= s_cnt_ff + 1'b1;
            s_wait_ff <= s_wait_ff + SlotWaitBits'(time_ff - s_head);
         end
      end
   end

   // Status toward the controller.
   assign slot_set = {1'b0, p_cnt_ff} + {1'b0, s_cnt_ff};
   always_comb begin
      status.action       = action_type'(req_tuser);
      status.priority_ok  = (p_count != '0) && (p_head <= time_ff);
      status.secondary_ok = (s_count != '0) && (s_head <= time_ff);
      status.quota_hit    = (p_cnt_ff >= quota_eff);
      status.slot_full    = (slot_set >= {1'b0, cap_ff});
      status.out_free     = !rsp_valid_ff || rsp_tready;
   end

   // Saturating running totals.
   always_comb begin
      ps_sum    = {1'b0, tot_ps_ff} + (TotalServedBits+1)'(p_cnt_ff);
      ss_sum    = {1'b0, tot_ss_ff} + (TotalServedBits+1)'(s_cnt_ff);
      pw_sum    = {1'b0, tot_pw_ff} + (TotalWaitBits+1)'(p_wait_ff);
      sw_sum    = {1'b0, tot_sw_ff} + (TotalWaitBits+1)'(s_wait_ff);
      tot_ps_in = ps_sum[TotalServedBits] ? '1 : ps_sum[TotalServedBits-1:0];
      tot_ss_in = ss_sum[TotalServedBits] ? '1 : ss_sum[TotalServedBits-1:0];
      tot_pw_in = pw_sum[TotalWaitBits] ? '1 : pw_sum[TotalWaitBits-1:0];
      tot_sw_in = sw_sum[TotalWaitBits] ? '1 : sw_sum[TotalWaitBits-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tot_ps_ff <= '0;
         tot_ss_ff <= '0;
         tot_pw_ff <= '0;
         tot_sw_ff <= '0;
      end else if (cmd.emit) begin
         tot_ps_ff <= tot_ps_in;
         tot_ss_ff <= tot_ss_in;
         tot_pw_ff <= tot_pw_in;
         tot_sw_ff <= tot_sw_in;
      end
   end

   // Result register; it holds until the consumer takes the result.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         rsp_user_ff <= drop_ff;
         rsp_data_ff <= {2'b00, tot_sw_in, tot_pw_in, tot_ss_in, tot_ps_in,
                         PendingBits'(s_count), PendingBits'(p_count),
                         s_wait_ff, p_wait_ff, s_cnt_ff, p_cnt_ff};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

endmodule

### src/tcqbs_ctrl.sv
// Controller: sequences arrivals, the three service passes and the result.
module tcqbs_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  tcqbs_pkg::status_type status,
   output tcqbs_pkg::cmd_type    cmd
);
   import tcqbs_pkg::*;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state and commands.
   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_tready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.load = 1'b1;
               case (status.action)
                  ACT_PRIORITY_ARRIVE,
                  ACT_SECONDARY_ARRIVE: state_in = ST_PUSH;
                  ACT_DEPART:           state_in = ST_PASS_QUOTA;
                  default:              state_in = ST_RESULT;
               endcase
            end
         end
         ST_PUSH: begin
            cmd.push = 1'b1;
            state_in = ST_RESULT;
         end
         // Priority heads up to the quota.
         ST_PASS_QUOTA: begin
            if (status.priority_ok && !status.quota_hit) begin
               cmd.pop_priority = 1'b1;
            end else begin
               state_in = ST_PASS_SECONDARY;
            end
         end
         // Secondary heads up to the capacity.
         ST_PASS_SECONDARY: begin
            if (status.secondary_ok && !status.slot_full) begin
               cmd.pop_secondary = 1'b1;
            end else begin
               state_in = ST_PASS_FILL;
            end
         end
         // Remaining room goes to further priority heads.
         ST_PASS_FILL: begin
            if (status.priority_ok && !status.slot_full) begin
               cmd.pop_priority = 1'b1;
            end else begin
               state_in = ST_RESULT;
            end
         end
         ST_RESULT: begin
            if (status.out_free) begin
               cmd.emit = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

endmodule

### src/two_class_quota_boarding_scheduler_unit.sv
// Two-class quota scheduler: an arrival goes from the push state to the result state.
// A departure runs the quota, secondary and fill passes, then the result state.
// The service passes dequeue one queue head per cycle from a registered memory read.
// One request is in work at a time; the result register frees the input side.
// Synchronous active-high reset empties both queues, clears the totals and
// restores capacity 10 and quota 8; queue memories are not cleared.
module two_class_quota_boarding_scheduler_unit #(
   parameter int QUEUE_DEPTH = 64
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   input  logic [tcqbs_pkg::ReqDataBits-1:0]     req_tdata,   // time_stamp
   input  logic [tcqbs_pkg::ActionBits-1:0]      req_tuser,   // action
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   // priority_served, secondary_served, priority_wait_sum, secondary_wait_sum,
   // priority_pending, secondary_pending, total_priority_served,
   // total_secondary_served, total_priority_wait, total_secondary_wait, zero pad
   output logic [tcqbs_pkg::RspDataBits-1:0]     rsp_tdata,
   output logic                                  rsp_tuser,   // status
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [tcqbs_pkg::CsrIndexBits-1:0]    csr_index,
   input  logic [tcqbs_pkg::CfgBits-1:0]         csr_data
);
   import tcqbs_pkg::*;

   cmd_type    cmd;
   status_type status;

   tcqbs_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   tcqbs_datapath #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .status     (status),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

endmodule

### src/tcqbs_checker.sv
// Port-level checker for the scheduler and its bind to the top level.
`include "two_class_quota_boarding_scheduler_unit_macros.svh"

module tcqbs_checker (
   input logic                                  clock,
   input logic                                  reset,
   input logic                                  req_tvalid,
   input logic                                  req_tready,
   input logic                                  rsp_tvalid,
   input logic                                  rsp_tready,
   input logic [tcqbs_pkg::RspDataBits-1:0]     rsp_tdata,
   input logic                                  rsp_tuser
);
   import tcqbs_pkg::*;

   logic                   req_take;
   logic                   rsp_stall;
   logic                   rsp_drop;
   logic                   p_idle;
   logic                   s_idle;
   logic [RspDataBits:0]   rsp_word;

   // Handshake and field conditions used by the properties below.
   assign req_take  = req_tvalid && req_tready;
   assign rsp_stall = rsp_tvalid && !rsp_tready;
   assign rsp_drop  = rsp_tvalid && rsp_tuser;
   assign p_idle    = rsp_tvalid && (rsp_tdata[3:0] == 4'd0);
   assign s_idle    = rsp_tvalid && (rsp_tdata[7:4] == 4'd0);
   assign rsp_word  = {rsp_tuser, rsp_tdata};

   // A stalled result keeps its contents.
   `TCQBS_ASSERT_NEXT(a_rsp_hold, rsp_stall, rsp_tvalid && $stable(rsp_word), "result not held")

   // Only one request is in work at a time.
   `TCQBS_ASSERT_NEXT(a_busy_after_accept, req_take, !req_tready, "request taken while busy")

   // A dropped arrival serves nothing.
   `TCQBS_ASSERT_IMPLY(a_drop_no_service, rsp_drop, rsp_tdata[47:0] == 48'd0, "drop with service")

   // No priority service means no priority wait.
   `TCQBS_ASSERT_IMPLY(a_priority_wait, p_idle, rsp_tdata[27:8] == 20'd0, "priority wait, none served")

   // No secondary service means no secondary wait.
   `TCQBS_ASSERT_IMPLY(a_secondary_wait, s_idle, rsp_tdata[47:28] == 20'd0, "secondary wait, none served")

endmodule

bind two_class_quota_boarding_scheduler_unit tcqbs_checker u_checker (.*);

### tb/two_class_quota_boarding_scheduler_unit_tb.sv
// Self-checking testbench for the two-class quota boarding scheduler unit.
module two_class_quota_boarding_scheduler_unit_tb;
   import tcqbs_pkg::*;

   localparam int QueueDepth = 64;
   localparam int PriorityClass = 0;
   localparam int SecondaryClass = 1;
   localparam int HoldCycles = 300;
   localparam int QuietLimit = 2000;
   localparam int DrainCycles = 24;
   localparam int unsigned MaxStamp = (1 << TimeBits) - 1;
   localparam logic [ActionBits-1:0] ActNone = 2'd3;
   localparam logic [63:0] SlotWaitCeiling = 64'hF_FFFF;
   localparam logic [63:0] ServedCeiling = 64'hFFFF_FFFF;
   localparam logic [63:0] WaitCeiling = 64'hFF_FFFF_FFFF;

   // Result fields, highest bits first, so that a cast from rsp_tdata lines up.
   typedef struct packed {
      logic [1:0]                 zero_pad;
      logic [TotalWaitBits-1:0]   total_secondary_wait;
      logic [TotalWaitBits-1:0]   total_priority_wait;
      logic [TotalServedBits-1:0] total_secondary_served;
      logic [TotalServedBits-1:0] total_priority_served;
      logic [PendingBits-1:0]     secondary_pending;
      logic [PendingBits-1:0]     priority_pending;
      logic [SlotWaitBits-1:0]    secondary_wait_sum;
      logic [SlotWaitBits-1:0]    priority_wait_sum;
      logic [ServedBits-1:0]      secondary_served;
      logic [ServedBits-1:0]      priority_served;
   } boarding_summary_t;

   typedef struct packed {
      logic              dropped;
      boarding_summary_t fields;
   } boarding_outcome_t;

   typedef struct packed {
      logic [ActionBits-1:0] kind;
      logic [TimeBits-1:0]   stamp;
   } boarding_req_t;

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    req_tvalid = 1'b0;
   logic                    req_tready;
   logic [ReqDataBits-1:0]  req_tdata = '0;
   logic [ActionBits-1:0]   req_tuser = '0;
   logic                    rsp_tvalid;
   logic                    rsp_tready = 1'b0;
   logic [RspDataBits-1:0]  rsp_tdata;
   logic                    rsp_tuser;
   logic                    csr_valid = 1'b0;
   logic                    csr_ready;
   logic [CsrIndexBits-1:0] csr_index = '0;
   logic [CfgBits-1:0]      csr_data = '0;

   two_class_quota_boarding_scheduler_unit DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   // Scheduler state as the testbench expects it to be.
   logic [TimeBits-1:0] queued_time [2][QueueDepth];
   int unsigned         queue_head [2];
   int unsigned         queue_count [2];
   logic [63:0]         served_total [2];
   logic [63:0]         wait_total [2];
   logic [CfgBits-1:0]  capacity_cfg = CapacityReset;
   logic [CfgBits-1:0]  quota_cfg = QuotaReset;

   boarding_req_t     waiting_reqs [$];
   boarding_outcome_t expected_outcomes [$];

   int          send_gap_pct = 0;
   int          recv_stall_pct = 0;
   int          hold_requests = 0;
   int          holds_started = 0;
   int          hold_left = 0;
   int          quiet_cycles = 0;
   int          mismatch_count = 0;
   int          results_seen = 0;
   int unsigned now_cursor = 0;

   initial begin
      forever #6 clock = ~clock;
   end

   // Boards heads of one class that arrived by the departure time until the
   // slot holds the given limit.
   function automatic int unsigned board_class(int cls, logic [TimeBits-1:0] depart_time,
         int unsigned taken, int unsigned limit, inout logic [63:0] wait_acc);
      int unsigned n = 0;
      logic [TimeBits-1:0] arrived;
      while (taken + n < limit && queue_count[cls] > 0) begin
         arrived = queued_time[cls][queue_head[cls]];
         if (arrived > depart_time) break;
         wait_acc = wait_acc + (depart_time - arrived);
         queue_head[cls] = (queue_head[cls] + 1) % QueueDepth;
         queue_count[cls] = queue_count[cls] - 1;
         n++;
      end
      return n;
   endfunction

   function automatic logic [63:0] sat_sum(logic [63:0] a, logic [63:0] b,
         logic [63:0] ceiling);
      return (a + b > ceiling) ? ceiling : a + b;
   endfunction

   // Applies one request to the expected state and returns the result it should give.
   function automatic boarding_outcome_t predict_boarding(logic [ActionBits-1:0] kind,
         logic [TimeBits-1:0] stamp);
      boarding_outcome_t res;
      int cls;
      int unsigned quota;
      int unsigned p_n = 0;
      int unsigned s_n = 0;
      logic [63:0] p_wait = '0;
      logic [63:0] s_wait = '0;
      res = '0;
      if (kind == ACT_PRIORITY_ARRIVE || kind == ACT_SECONDARY_ARRIVE) begin
         cls = (kind == ACT_PRIORITY_ARRIVE) ? PriorityClass : SecondaryClass;
         if (queue_count[cls] >= QueueDepth) begin
            res.dropped = 1'b1;
         end else begin
            queued_time[cls][(queue_head[cls] + queue_count[cls]) % QueueDepth] = stamp;
            queue_count[cls] = queue_count[cls] + 1;
         end
      end else if (kind == ACT_DEPART) begin
         quota = (quota_cfg > capacity_cfg) ? capacity_cfg : quota_cfg;
         p_n = board_class(PriorityClass, stamp, 0, quota, p_wait);
         s_n = board_class(SecondaryClass, stamp, p_n, capacity_cfg, s_wait);
         p_n += board_class(PriorityClass, stamp, p_n + s_n, capacity_cfg, p_wait);
         served_total[PriorityClass] = sat_sum(served_total[PriorityClass], p_n, ServedCeiling);
         served_total[SecondaryClass] =
            sat_sum(served_total[SecondaryClass], s_n, ServedCeiling);
         wait_total[PriorityClass] = sat_sum(wait_total[PriorityClass], p_wait, WaitCeiling);
         wait_total[SecondaryClass] = sat_sum(wait_total[SecondaryClass], s_wait, WaitCeiling);
         if (p_wait > SlotWaitCeiling) p_wait = SlotWaitCeiling;
         if (s_wait > SlotWaitCeiling) s_wait = SlotWaitCeiling;
         res.fields.priority_served = p_n[ServedBits-1:0];
         res.fields.secondary_served = s_n[ServedBits-1:0];
         res.fields.priority_wait_sum = p_wait[SlotWaitBits-1:0];
         res.fields.secondary_wait_sum = s_wait[SlotWaitBits-1:0];
      end
      res.fields.priority_pending = queue_count[PriorityClass][PendingBits-1:0];
      res.fields.secondary_pending = queue_count[SecondaryClass][PendingBits-1:0];
      res.fields.total_priority_served = served_total[PriorityClass][TotalServedBits-1:0];
      res.fields.total_secondary_served = served_total[SecondaryClass][TotalServedBits-1:0];
      res.fields.total_priority_wait = wait_total[PriorityClass][TotalWaitBits-1:0];
      res.fields.total_secondary_wait = wait_total[SecondaryClass][TotalWaitBits-1:0];
      return res;
   endfunction

   // Prints one line per mismatch and counts it.
   task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
      mismatch_count++;
      $display("result %0d: %s is 0x%0h, expected 0x%0h", results_seen, what, got, want);
   endtask

   task automatic check_field(string what, logic [63:0] got, logic [63:0] want);
      if (got !== want) report_mismatch(what, got, want);
   endtask

   // Request driver: presents queued requests, predicting each one as it is taken.
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready)
            expected_outcomes.push_back(predict_boarding(req_tuser, req_tdata));
         if (!req_tvalid || req_tready) begin
            if (waiting_reqs.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
               req_tvalid <= 1'b1;
               req_tdata <= waiting_reqs[0].stamp;
               req_tuser <= waiting_reqs[0].kind;
               void'(waiting_reqs.pop_front());
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // Long receiver hold-off, counted here so the sender keeps pushing requests.
   always @(posedge clock) begin
      if (reset) begin
         hold_left <= 0;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
      end else if (holds_started != hold_requests) begin
         hold_left <= HoldCycles;
         holds_started <= holds_started + 1;
      end
   end

   // Result monitor: compares every accepted result with the oldest expectation.
   always @(posedge clock) begin : result_monitor
      boarding_outcome_t want;
      boarding_summary_t seen;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= (hold_left == 0) && ($urandom_range(99) >= recv_stall_pct);
         if (rsp_tvalid && rsp_tready) begin
            seen = rsp_tdata;
            results_seen++;
            if (expected_outcomes.size() == 0) begin
               report_mismatch("result with no request waiting", 64'd1, 64'd0);
            end else begin
               want = expected_outcomes.pop_front();
               check_field("status", rsp_tuser, want.dropped);
               check_field("priority_served", seen.priority_served,
                  want.fields.priority_served);
               check_field("secondary_served", seen.secondary_served,
                  want.fields.secondary_served);
               check_field("priority_wait_sum", seen.priority_wait_sum,
                  want.fields.priority_wait_sum);
               check_field("secondary_wait_sum", seen.secondary_wait_sum,
                  want.fields.secondary_wait_sum);
               check_field("priority_pending", seen.priority_pending,
                  want.fields.priority_pending);
               check_field("secondary_pending", seen.secondary_pending,
                  want.fields.secondary_pending);
               check_field("total_priority_served", seen.total_priority_served,
                  want.fields.total_priority_served);
               check_field("total_secondary_served", seen.total_secondary_served,
                  want.fields.total_secondary_served);
               check_field("total_priority_wait", seen.total_priority_wait,
                  want.fields.total_priority_wait);
               check_field("total_secondary_wait", seen.total_secondary_wait,
                  want.fields.total_secondary_wait);
            end
         end
      end
   end

   // Watchdog: ends the run when no handshake of any kind happens for too long.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)
            || (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QuietLimit) begin
         $display("two_class_quota_boarding_scheduler_unit: mismatch");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic add_req(logic [ActionBits-1:0] kind, logic [TimeBits-1:0] stamp);
      boarding_req_t r;
      r.kind = kind;
      r.stamp = stamp;
      waiting_reqs.push_back(r);
   endtask

   // Waits until every request has been answered, then lets the block go quiet.
   task automatic settle();
      do @(negedge clock);
      while (waiting_reqs.size() != 0 || req_tvalid || expected_outcomes.size() != 0);
      repeat (DrainCycles) @(negedge clock);
   endtask

   task automatic write_csr(logic [CsrIndexBits-1:0] idx, logic [CfgBits-1:0] val);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      if (idx == CSR_SLOT_CAPACITY) capacity_cfg = val;
      else quota_cfg = val;
      @(negedge clock);
   endtask

   // Arrival stamps sit near the running time, now and then far in the future.
   function automatic logic [TimeBits-1:0] arrival_stamp();
      int unsigned t;
      t = now_cursor + (($urandom_range(19) == 0) ? $urandom_range(3000) : $urandom_range(40));
      return (t > MaxStamp) ? MaxStamp[TimeBits-1:0] : t[TimeBits-1:0];
   endfunction

   // Mostly ordered traffic with random content, plus some noise requests.
   task automatic queue_random_traffic(int unsigned n);
      int unsigned roll;
      for (int unsigned k = 0; k < n; k++) begin
         // Near the top of the time range, depart at the largest stamp to drain the queues and start over low.
         if (now_cursor > 60000) begin
            repeat (8) add_req(ACT_DEPART, MaxStamp[TimeBits-1:0]);
            now_cursor = $urandom_range(300);
         end
         roll = $urandom_range(99);
         if (roll < 40) begin
            add_req(ACT_PRIORITY_ARRIVE, arrival_stamp());
         end else if (roll < 76) begin
            add_req(ACT_SECONDARY_ARRIVE, arrival_stamp());
         end else if (roll < 95) begin
            now_cursor += ($urandom_range(9) == 0) ? $urandom_range(8000) : $urandom_range(50);
            if (now_cursor > MaxStamp) now_cursor = MaxStamp;
            add_req(ACT_DEPART, now_cursor[TimeBits-1:0]);
         end else if (roll < 97) begin
            add_req(ActNone, TimeBits'($urandom));
         end else begin
            add_req(roll[0] ? ACT_PRIORITY_ARRIVE : ACT_SECONDARY_ARRIVE, TimeBits'($urandom));
         end
      end
   endtask

   task automatic run_random_phase(logic [CfgBits-1:0] cap, logic [CfgBits-1:0] quota,
         int gap, int stall, int unsigned n, bit hold);
      write_csr(CSR_SLOT_CAPACITY, cap);
      write_csr(CSR_PRIORITY_QUOTA, quota);
      send_gap_pct = gap;
      recv_stall_pct = stall;
      if (hold) hold_requests++;
      queue_random_traffic(n);
      settle();
   endtask

   initial begin
      for (int c = 0; c < 2; c++) begin
         queue_head[c] = 0;
         queue_count[c] = 0;
         served_total[c] = '0;
         wait_total[c] = '0;
      end
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed requests at the reset configuration.
      add_req(ActNone, 16'hFFFF);
      add_req(ACT_DEPART, 16'h0000);
      add_req(ACT_PRIORITY_ARRIVE, 16'h0000);
      add_req(ACT_PRIORITY_ARRIVE, 16'h0000);
      add_req(ACT_SECONDARY_ARRIVE, 16'h0000);
      add_req(ACT_DEPART, 16'h0000);
      // A late secondary head blocks an earlier entry queued behind it.
      add_req(ACT_SECONDARY_ARRIVE, 16'd100);
      add_req(ACT_SECONDARY_ARRIVE, 16'd50);
      add_req(ACT_PRIORITY_ARRIVE, 16'd10);
      add_req(ACT_DEPART, 16'd60);
      add_req(ACT_DEPART, 16'd100);
      // Largest possible waits.
      add_req(ACT_PRIORITY_ARRIVE, 16'h0000);
      add_req(ACT_PRIORITY_ARRIVE, 16'h0000);
      add_req(ACT_SECONDARY_ARRIVE, 16'h0000);
      add_req(ActNone, 16'h0000);
      add_req(ACT_DEPART, 16'hFFFF);
      add_req(ACT_PRIORITY_ARRIVE, 16'hFFFF);
      add_req(ACT_DEPART, 16'hFFFF);
      settle();

      // Overfill both queues so arrivals are dropped, then drain them.
      write_csr(CSR_SLOT_CAPACITY, 4'd15);
      write_csr(CSR_PRIORITY_QUOTA, 4'd15);
      send_gap_pct = 52;
      for (int i = 0; i < QueueDepth + 2; i++) add_req(ACT_PRIORITY_ARRIVE, 16'(1000 + i));
      for (int i = 0; i < QueueDepth + 2; i++) add_req(ACT_SECONDARY_ARRIVE, 16'(2000 + i));
      add_req(ActNone, 16'h5A5A);
      repeat (10) add_req(ACT_DEPART, 16'hFFFF);
      settle();

      now_cursor = 0;
      run_random_phase(4'd1, 4'd0, 0, 0, 60, 1'b0);
      run_random_phase(4'd15, 4'd0, 52, 0, 60, 1'b0);
      run_random_phase(4'd0, 4'd15, 0, 52, 20, 1'b0);
      run_random_phase(4'd7, 4'd3, 6, 6, 60, 1'b0);
      run_random_phase(4'd4, 4'd15, 0, 0, 60, 1'b1);
      run_random_phase(4'($urandom_range(1, 15)), 4'($urandom_range(15)), 0, 52, 60, 1'b0);
      run_random_phase(4'd10, 4'd8, 52, 0, 40, 1'b0);

      if (mismatch_count == 0)
         $display("two_class_quota_boarding_scheduler_unit: match");
      else
         $display("two_class_quota_boarding_scheduler_unit: mismatch");
      $finish;
   end

endmodule
